// ----- rtl/qrs_pkg.sv -----
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int OUT_FRAC = 16;
  localparam int ROOT_W   = 32;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_TWO    = 2'd2,
    ST_DEGEN  = 2'd3
  } root_status_t;

  // control that rides along with each request through the pipeline
  typedef struct packed {
    logic         valid;
    root_status_t status;
    logic         neg;
    logic [1:0]   low2;
  } ctrl_t;

endpackage

// ----- rtl/quadratic_root_solver.sv -----
`timescale 1ns / 1ps
// Real roots of a*x^2 + b*x + c = 0 from signed fixed-point coefficients. Accepts one
// coefficient set per cycle while the output is not stalled; each result passes through the
// square-root stages (one bit each, COEF_WIDTH of them) and the two parallel dividers (one
// quotient bit each, COEF_WIDTH + 19 stages). The whole pipeline holds while a result waits on
// m_axis_tready. Roots come out in Q16.16, truncated toward zero and clipped with the saturated
// flag; a zero leading coefficient reports status 3 with zero roots.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coef_quad, coef_lin, coef_const, zero pad
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // root_plus, root_minus
  output logic [2*ROOT_W-1:0]                 m_axis_tdata,
  // root_status, saturated
  output logic [2:0]                          m_axis_tuser
);

  localparam int W   = COEF_WIDTH;
  localparam int XW  = 2 * W;
  localparam int NW  = W + 3;
  localparam int DVW = W + 1;
  localparam int DW  = NW + OUT_FRAC;
  localparam int QX  = (DW > ROOT_W + 1) ? DW : ROOT_W + 1;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: magnitudes and signs
  logic [W-1:0] a_in, b_in, c_in;
  assign a_in = s_axis_tdata[W-1:0];
  assign b_in = s_axis_tdata[2*W-1:W];
  assign c_in = s_axis_tdata[3*W-1:2*W];

  ctrl_t        s1_ctrl;
  logic [W-1:0] s1_amag, s1_bmag, s1_cmag, s1_b;
  logic         s1_ac_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (en) begin
      s1_ctrl.valid  <= s_axis_tvalid;
      s1_ctrl.status <= (a_in == '0) ? ST_DEGEN : ST_TWO;
      s1_ctrl.neg    <= a_in[W-1];
      s1_ctrl.low2   <= 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_amag   <= a_in[W-1] ? (~a_in + 1'b1) : a_in;
      s1_bmag   <= b_in[W-1] ? (~b_in + 1'b1) : b_in;
      s1_cmag   <= c_in[W-1] ? (~c_in + 1'b1) : c_in;
      s1_b      <= b_in;
      s1_ac_neg <= a_in[W-1] ^ c_in[W-1];
    end
  end

  // stage 2: b^2 and |a||c|
  ctrl_t         s2_ctrl;
  logic [XW-1:0] s2_b2, s2_q;
  logic [W-1:0]  s2_amag, s2_b;
  logic          s2_ac_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
    end else if (en) begin
      s2_ctrl <= s1_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_b2     <= s1_bmag * s1_bmag;
      s2_q      <= s1_amag * s1_cmag;
      s2_amag   <= s1_amag;
      s2_b      <= s1_b;
      s2_ac_neg <= s1_ac_neg;
    end
  end

  // stage 3: D = 4x + r, classify
  logic [XW-1:0] b2q, x_next;
  ctrl_t         ctrl3_next;

  always_comb begin
    b2q        = {2'b00, s2_b2[XW-1:2]};
    ctrl3_next = s2_ctrl;
    ctrl3_next.low2 = s2_b2[1:0];
    x_next     = '0;
    if (s2_ctrl.status != ST_DEGEN) begin
      if (s2_q != '0 && s2_ac_neg) begin
        x_next = b2q + s2_q;
      end else if (b2q < s2_q) begin
        ctrl3_next.status = ST_NONE;
      end else begin
        x_next = b2q - s2_q;
      end
      if (ctrl3_next.status != ST_NONE) begin
        ctrl3_next.status = (x_next == '0 && s2_b2[1:0] == 2'b00) ? ST_DOUBLE : ST_TWO;
      end
    end
  end

  ctrl_t         s3_ctrl;
  logic [XW-1:0] s3_x;
  logic [W-1:0]  s3_amag, s3_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctrl <= '0;
    end else if (en) begin
      s3_ctrl <= ctrl3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x    <= x_next;
      s3_amag <= s2_amag;
      s3_b    <= s2_b;
    end
  end

  // t = floor(sqrt(x)), e = x - t^2
  ctrl_t        sq_ctrl;
  logic [W-1:0] sq_b, sq_amag, sq_root;
  logic [W+1:0] sq_rem;

  qrs_sqrt #(.W(W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctrl  (s3_ctrl),
    .in_x     (s3_x),
    .in_b     (s3_b),
    .in_amag  (s3_amag),
    .out_ctrl (sq_ctrl),
    .out_b    (sq_b),
    .out_amag (sq_amag),
    .out_root (sq_root),
    .out_rem  (sq_rem)
  );

  // stage 4: s = 2t or 2t+1, numerators -b +/- s
  logic [W+3:0]  lhs, rhs;
  logic [W:0]    s_val;
  logic [NW-1:0] nb, s_ext, np, nm;
  ctrl_t         ctrl_p_next, ctrl_m_next;

  always_comb begin
    lhs   = {sq_rem, 2'b00} + {{(W + 2){1'b0}}, sq_ctrl.low2};
    rhs   = {2'b00, sq_root, 2'b01};
    s_val = {sq_root, lhs >= rhs};
    nb    = ~{{3{sq_b[W-1]}}, sq_b} + 1'b1;
    s_ext = {2'b00, s_val};
    np    = nb + s_ext;
    nm    = nb - s_ext;
    ctrl_p_next     = sq_ctrl;
    ctrl_p_next.neg = np[NW-1] ^ sq_ctrl.neg;
    ctrl_m_next     = sq_ctrl;
    ctrl_m_next.neg = nm[NW-1] ^ sq_ctrl.neg;
  end

  ctrl_t          s4_ctrl_p, s4_ctrl_m;
  logic [NW-1:0]  s4_mag_p, s4_mag_m;
  logic [DVW-1:0] s4_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctrl_p <= '0;
      s4_ctrl_m <= '0;
    end else if (en) begin
      s4_ctrl_p <= ctrl_p_next;
      s4_ctrl_m <= ctrl_m_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mag_p <= np[NW-1] ? (~np + 1'b1) : np;
      s4_mag_m <= nm[NW-1] ? (~nm + 1'b1) : nm;
      s4_den   <= {sq_amag, 1'b0};
    end
  end

  ctrl_t         dv_ctrl_p, dv_ctrl_m;
  logic [DW-1:0] quo_p, quo_m;

  qrs_div #(.NW(NW), .DVW(DVW)) u_div_plus (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctrl  (s4_ctrl_p),
    .in_num   (s4_mag_p),
    .in_den   (s4_den),
    .out_ctrl (dv_ctrl_p),
    .out_quo  (quo_p)
  );

  qrs_div #(.NW(NW), .DVW(DVW)) u_div_minus (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctrl  (s4_ctrl_m),
    .in_num   (s4_mag_m),
    .in_den   (s4_den),
    .out_ctrl (dv_ctrl_m),
    .out_quo  (quo_m)
  );

  // {sat, value}: apply sign, clip to signed 32 bits
  function automatic logic [ROOT_W:0] clip_root(input logic [DW-1:0] quo, input logic neg);
    logic [QX-1:0]     qx;
    logic [QX-1:0]     lim;
    logic              sat;
    logic [ROOT_W-1:0] val;
    qx  = QX'(quo);
    lim = neg ? QX'(64'h8000_0000) : QX'(64'h7FFF_FFFF);
    sat = qx > lim;
    val = sat ? lim[ROOT_W-1:0] : qx[ROOT_W-1:0];
    if (neg) begin
      val = ~val + 1'b1;
    end
    return {sat, val};
  endfunction

  logic [ROOT_W:0] rp, rmn;
  logic            has_roots;

  always_comb begin
    rp        = clip_root(quo_p, dv_ctrl_p.neg);
    rmn       = clip_root(quo_m, dv_ctrl_m.neg);
    has_roots = dv_ctrl_p.status == ST_DOUBLE || dv_ctrl_p.status == ST_TWO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_ctrl_p.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (has_roots) begin
        m_axis_tdata <= {rmn[ROOT_W-1:0], rp[ROOT_W-1:0]};
        m_axis_tuser <= {rp[ROOT_W] | rmn[ROOT_W], dv_ctrl_p.status};
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= {1'b0, dv_ctrl_p.status};
      end
    end
  end

endmodule

// ----- rtl/qrs_sqrt.sv -----
`timescale 1ns / 1ps
module qrs_sqrt import qrs_pkg::*; #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ctrl_t          in_ctrl,
  input  logic [2*W-1:0] in_x,
  input  logic [W-1:0]   in_b,
  input  logic [W-1:0]   in_amag,
  output ctrl_t          out_ctrl,
  output logic [W-1:0]   out_b,
  output logic [W-1:0]   out_amag,
  output logic [W-1:0]   out_root,
  output logic [W+1:0]   out_rem
);

  localparam int XW = 2 * W;

  ctrl_t          ctrl_s [W+1];
  logic [XW-1:0]  xs     [W+1];
  logic [W-1:0]   root_s [W+1];
  logic [W+1:0]   rem_s  [W+1];
  logic [W-1:0]   b_s    [W+1];
  logic [W-1:0]   amag_s [W+1];

  assign ctrl_s[0] = in_ctrl;
  assign xs[0]     = in_x;
  assign root_s[0] = '0;
  assign rem_s[0]  = '0;
  assign b_s[0]    = in_b;
  assign amag_s[0] = in_amag;

  // one result bit per stage, restoring digit recurrence
  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W+1:0] cur;
    logic [W+1:0] trial;
    logic         ge;

    assign cur   = {rem_s[i][W-1:0], xs[i][XW-1 -: 2]};
    assign trial = {root_s[i], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_s[i+1] <= '0;
      end else if (en) begin
        ctrl_s[i+1] <= ctrl_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1]     <= {xs[i][XW-3:0], 2'b00};
        root_s[i+1] <= {root_s[i][W-2:0], ge};
        rem_s[i+1]  <= ge ? (cur - trial) : cur;
        b_s[i+1]    <= b_s[i];
        amag_s[i+1] <= amag_s[i];
      end
    end
  end

  assign out_ctrl = ctrl_s[W];
  assign out_b    = b_s[W];
  assign out_amag = amag_s[W];
  assign out_root = root_s[W];
  assign out_rem  = rem_s[W];

endmodule

// ----- rtl/qrs_div.sv -----
`timescale 1ns / 1ps
module qrs_div import qrs_pkg::*; #(
  parameter int NW  = 19,
  parameter int DVW = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  ctrl_t                  in_ctrl,
  input  logic [NW-1:0]          in_num,
  input  logic [DVW-1:0]         in_den,
  output ctrl_t                  out_ctrl,
  output logic [NW+OUT_FRAC-1:0] out_quo
);

  localparam int DW = NW + OUT_FRAC;

  ctrl_t          ctrl_s [DW+1];
  logic [DW-1:0]  dq     [DW+1];
  logic [DVW-1:0] rm     [DW+1];
  logic [DVW-1:0] den_s  [DW+1];

  assign ctrl_s[0] = in_ctrl;
  assign dq[0]     = {in_num, {OUT_FRAC{1'b0}}};
  assign rm[0]     = '0;
  assign den_s[0]  = in_den;

  // dividend shifts out the top while quotient bits fill in at the bottom
  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [DVW:0] cur;
    logic [DVW:0] diff;
    logic         ge;

    assign cur  = {rm[i], dq[i][DW-1]};
    assign diff = cur - {1'b0, den_s[i]};
    assign ge   = cur >= {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_s[i+1] <= '0;
      end else if (en) begin
        ctrl_s[i+1] <= ctrl_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq[i+1]    <= {dq[i][DW-2:0], ge};
        rm[i+1]    <= ge ? diff[DVW-1:0] : cur[DVW-1:0];
        den_s[i+1] <= den_s[i];
      end
    end
  end

  assign out_ctrl = ctrl_s[DW];
  assign out_quo  = dq[DW];

endmodule

// ----- rtl/qrs_check.sv -----
`timescale 1ns / 1ps
module qrs_check import qrs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [2*ROOT_W-1:0] m_axis_tdata,
  input logic [2:0]          m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_no_roots_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[1:0] == ST_NONE || m_axis_tuser[1:0] == ST_DEGEN) |->
      m_axis_tdata == '0 && !m_axis_tuser[2])
    else $error("nonzero roots without real roots");

  a_double_equal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1:0] == ST_DOUBLE |->
      m_axis_tdata[ROOT_W-1:0] == m_axis_tdata[2*ROOT_W-1:ROOT_W])
    else $error("double root halves differ");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not track output stall");

endmodule

bind quadratic_root_solver qrs_check u_qrs_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/quadratic_root_solver_test.sv -----
`timescale 1ns / 1ps
module quadratic_root_solver_test import qrs_pkg::*;;

  localparam int CW = 16;
  localparam int DW = ((3*CW+7)/8)*8;
  localparam int LATENCY = 2*CW + 24;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    root_status_t status;
    logic [31:0]  rplus;
    logic [31:0]  rminus;
    logic         sat;
  } roots_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [2*ROOT_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  roots_t expected_roots[$];
  int mismatches;
  int requests_sent;
  int results_seen;
  int status_count[4];
  int idle_cycles;
  bit hold_off;
  bit out_random;

  quadratic_root_solver #(.COEF_WIDTH(CW)) dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // (num << 16) / (2a), truncated toward zero, clipped to 32 bits
  function automatic logic [31:0] scaled_quotient(input longint num, input longint a,
                                                   inout logic sat);
    logic [63:0] mn, den, quo;
    mn = (num < 0) ? -num : num;
    den = ((a < 0) ? -a : a) << 1;
    quo = (mn << OUT_FRAC) / den;
    if ((num < 0) != (a < 0)) begin
      if (quo > 64'h8000_0000) begin
        sat = 1;
        quo = 64'h8000_0000;
      end
      return -quo[31:0];
    end
    if (quo > 64'h7FFF_FFFF) begin
      sat = 1;
      quo = 64'h7FFF_FFFF;
    end
    return quo[31:0];
  endfunction

  function automatic roots_t solve_roots(input logic signed [CW-1:0] qa,
                                         input logic signed [CW-1:0] qb,
                                         input logic signed [CW-1:0] qc);
    roots_t res;
    longint a, b, c, disc, s;
    logic sat;
    a = qa;
    b = qb;
    c = qc;
    res = '0;
    sat = 0;
    // 16-bit coefficients keep b^2 - 4ac well inside 64 bits
    disc = b*b - 4*a*c;
    if (a == 0) res.status = ST_DEGEN;
    else if (disc < 0) res.status = ST_NONE;
    else if (disc == 0) begin
      res.status = ST_DOUBLE;
      res.rplus = scaled_quotient(-b, a, sat);
      res.rminus = res.rplus;
    end else begin
      s = int_sqrt(disc);
      res.status = ST_TWO;
      res.rplus = scaled_quotient(-b + s, a, sat);
      res.rminus = scaled_quotient(-b - s, a, sat);
    end
    res.sat = sat;
    return res;
  endfunction

  // valid stays up across zero-gap requests; dropped only while idling
  task automatic send_coefs(input logic [CW-1:0] qa, input logic [CW-1:0] qb,
                            input logic [CW-1:0] qc, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {{(DW-3*CW){1'b0}}, qc, qb, qa};
    s_axis_tvalid <= 1;
    expected_roots.push_back(solve_roots(qa, qb, qc));
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_random(input int gap);
    logic [CW-1:0] qa, qb, qc;
    qa = CW'($urandom);
    qb = CW'($urandom);
    qc = CW'($urandom);
    case ($urandom_range(0, 5))
      0: qa = CW'($urandom_range(0, 3) - 1);
      1: begin
        qa = CW'($urandom_range(1, 255));
        qb = CW'($urandom_range(0, 4095));
        qc = CW'($urandom_range(0, 4095));
      end
      2: begin
        // perfect square: b = 2k, c = k^2/a with a = 1 (Q8.8 raw units)
        qa = 1;
        qb = CW'($urandom_range(0, 180) * 2);
        qc = (qb/2) * (qb/2);
      end
      default: ;
    endcase
    send_coefs(qa, qb, qc, gap);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_coefs(16'h0000, 16'h1234, 16'h5678, 0);
    send_coefs(16'h0000, 16'h0000, 16'h0000, 0);
    send_coefs(16'h0100, 16'h0000, 16'h0100, 0);
    send_coefs(16'h0100, 16'hFE00, 16'h0100, 0);
    send_coefs(16'h0100, 16'h0000, 16'hFF00, 0);
    send_coefs(16'h0100, 16'hFD00, 16'h0200, 0);
    send_coefs(16'h8000, 16'h8000, 16'h8000, 0);
    send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_coefs(16'h8000, 16'h7FFF, 16'h7FFF, 0);
    send_coefs(16'h7FFF, 16'h8000, 16'h8000, 0);
    send_coefs(16'h0001, 16'h7FFF, 16'h8000, 0);
    send_coefs(16'hFFFF, 16'h8000, 16'h7FFF, 0);
    send_coefs(16'h0001, 16'h0002, 16'h0001, 0);
    send_coefs(16'hFFFF, 16'h0000, 16'h0000, 0);
    send_coefs(16'h0001, 16'h8000, 16'h0000, 0);
    send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_coefs(16'h5555, 16'hAAAA, 16'h5555, 0);
    send_coefs(16'hAAAA, 16'h5555, 16'hAAAA, 0);
    wait_drained();
  endtask

  task automatic test_random();
    out_random = 1;
    for (int i = 0; i < 400; i++) begin
      // back-to-back stretches between gappy ones
      send_random(((i / 50) % 2) ? $urandom_range(0, 9) : 0);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 100; i++) send_random(0);
    join
    wait_drained();
  endtask

  // result check
  always @(posedge clk) begin
    roots_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = root_status_t'(m_axis_tuser[1:0]);
      got.sat = m_axis_tuser[2];
      got.rplus = m_axis_tdata[31:0];
      got.rminus = m_axis_tdata[63:32];
      results_seen++;
      if (expected_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_roots.pop_front();
        status_count[want.status]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d plus %h minus %h sat %b, got %0d %h %h %b",
                     want.status, want.rplus, want.rminus, want.sat,
                     got.status, got.rplus, got.rminus, got.sat);
        end
      end
    end
  end

  // receiver readiness: random-length stalls after results once random phase starts
  initial begin
    int wait_n;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_axis_tready <= 0;
      else if (m_axis_tready && m_axis_tvalid && out_random) begin
        wait_n = $urandom_range(0, 9);
        if (wait_n != 0) begin
          m_axis_tready <= 0;
          repeat (wait_n - 1) @(posedge clk);
        end
      end else m_axis_tready <= 1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1;
    s_axis_tvalid <= 0;
    s_axis_tdata <= '0;
    requests_sent = 0;
    hold_off = 0;
    out_random = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    $display("%0d coefficient sets, %0d results: none %0d, double %0d, two %0d, degenerate %0d",
             requests_sent, results_seen, status_count[0], status_count[1],
             status_count[2], status_count[3]);
    $display("random gaps, receiver stalls and one long output hold-off were exercised");
    if (mismatches == 0 && expected_roots.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
